[src/multi_mode_string_hash_macros.svh]
// Assertion helpers shared by the string hash RTL.
`ifndef MULTI_MODE_STRING_HASH_MACROS_SVH
`define MULTI_MODE_STRING_HASH_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MMSH_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mmsh check failed");

// Next-cycle implication, checked outside reset.
`define MMSH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mmsh check failed");

`endif

[src/mmsh_pkg.sv]
package mmsh_pkg;

    localparam int HASH_W = 32;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 16;
    localparam int MODE_W = 4;

    typedef logic [HASH_W-1:0] word_t;
    typedef logic [MODE_W-1:0] mode_t;

    localparam mode_t MODE_RS   = 4'd0;
    localparam mode_t MODE_JS   = 4'd1;
    localparam mode_t MODE_PJW  = 4'd2;
    localparam mode_t MODE_ELF  = 4'd3;
    localparam mode_t MODE_BKDR = 4'd4;
    localparam mode_t MODE_SDBM = 4'd5;
    localparam mode_t MODE_DJB  = 4'd6;
    localparam mode_t MODE_DEK  = 4'd7;
    localparam mode_t MODE_BP   = 4'd8;
    localparam mode_t MODE_FNV  = 4'd9;
    localparam mode_t MODE_AP   = 4'd10;

    localparam word_t RS_MUL_SEED = 32'd63689;
    localparam word_t RS_MUL_STEP = 32'd378551;
    localparam word_t JS_SEED     = 32'd1315423911;
    localparam word_t HIGH_NIBBLE = 32'hF000_0000;
    localparam word_t BKDR_MUL    = 32'd131;
    localparam word_t DJB_SEED    = 32'd5381;
    localparam word_t FNV_MUL     = 32'h811C_9DC5;
    localparam word_t AP_SEED     = 32'hAAAA_AAAA;

endpackage

[src/mmsh_channels.sv]
interface mmsh_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [mmsh_pkg::MODE_W-1:0] hash_mode;

    modport source (output valid, output hash_mode, input ready);
    modport sink   (input valid, input hash_mode, output ready);
endinterface

interface mmsh_msg_if;
    logic                        valid;
    logic                        ready;
    logic [mmsh_pkg::BYTE_W-1:0] data_byte;
    logic                        first_byte;
    logic                        last_byte;
    logic [mmsh_pkg::LEN_W-1:0]  msg_len;

    modport source (output valid, output data_byte, output first_byte, output last_byte,
                    output msg_len, input ready);
    modport sink   (input valid, input data_byte, input first_byte, input last_byte,
                    input msg_len, output ready);
endinterface

interface mmsh_hash_if;
    logic                        valid;
    logic                        ready;
    logic [mmsh_pkg::HASH_W-1:0] hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink   (input valid, input hash_value, output ready);
endinterface

[src/multi_mode_string_hash.sv]
// Channel   Modport   Payload                                      Role
// cfg       sink      hash_mode[3:0]                               mode register write
// msg       sink      data_byte[7:0] first_byte last_byte msg_len  one message byte
// hash      source    hash_value[31:0]                             hash after the last byte
//
// One byte per cycle sustained while the output is not stalled. A byte is registered
// in stage 1 on acceptance and folded into the running hash when it leaves stage 1;
// a last byte loads the output register at that same edge.
// The fold (a shared 32x32 multiplier, an add, the RS step multiplier) sets the rate.
// Reset sets the mode to RS, clears the running hash and all valids, and reloads the
// RS multiplier seed.
// A stalled output holds only a last byte; bytes behind a held last byte wait.
`include "multi_mode_string_hash_macros.svh"

module multi_mode_string_hash (
    input logic         clk,
    input logic         rst_n,
    mmsh_cfg_if.sink    cfg,
    mmsh_msg_if.sink    msg,
    mmsh_hash_if.source hash
);

    mmsh_pkg::mode_t mode_reg;

    logic                        s1_valid_reg;
    logic [mmsh_pkg::BYTE_W-1:0] s1_byte_reg;
    logic                        s1_first_reg;
    logic                        s1_last_reg;
    logic [mmsh_pkg::LEN_W-1:0]  s1_len_reg;
    logic                        s1_fire;

    mmsh_pkg::word_t hash_reg;
    mmsh_pkg::word_t hash_next;
    mmsh_pkg::word_t rsm_reg;
    mmsh_pkg::word_t rsm_next;
    logic            odd_reg;

    logic            out_valid_reg;
    logic            out_valid_next;
    mmsh_pkg::word_t out_hash_reg;

    mmsh_pkg::word_t c;
    mmsh_pkg::word_t seed;
    mmsh_pkg::word_t h0;
    mmsh_pkg::word_t rsm0;
    logic            odd0;
    mmsh_pkg::word_t mul_a;
    mmsh_pkg::word_t mul_b;
    mmsh_pkg::word_t mul_p;
    mmsh_pkg::word_t rsm_step;
    mmsh_pkg::word_t nib;

    // Mode register; the user must write it only while idle, the block does not enforce it
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= mmsh_pkg::MODE_RS;
        end
        else if (cfg.valid)
        begin
            mode_reg <= cfg.hash_mode;
        end
    end

    // Hold a byte in stage 1 until it can fold; a last byte also needs the output slot
    assign s1_fire   = s1_valid_reg && (!s1_last_reg || !out_valid_reg || hash.ready);
    assign msg.ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (msg.ready)
        begin
            s1_valid_reg <= msg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (msg.valid && msg.ready)
        begin
            s1_byte_reg  <= msg.data_byte;
            s1_first_reg <= msg.first_byte;
            s1_last_reg  <= msg.last_byte;
            s1_len_reg   <= msg.msg_len;
        end
    end

    // Fold
    assign c = {{(mmsh_pkg::HASH_W-mmsh_pkg::BYTE_W){s1_byte_reg[mmsh_pkg::BYTE_W-1]}},
                s1_byte_reg};

    always_comb
    begin
        case (mode_reg)
            mmsh_pkg::MODE_JS:  seed = mmsh_pkg::JS_SEED;
            mmsh_pkg::MODE_DJB: seed = mmsh_pkg::DJB_SEED;
            mmsh_pkg::MODE_DEK: seed = {{(mmsh_pkg::HASH_W-mmsh_pkg::LEN_W){1'b0}}, s1_len_reg};
            mmsh_pkg::MODE_AP:  seed = mmsh_pkg::AP_SEED;
            default:            seed = '0;
        endcase
    end

    assign h0   = s1_first_reg ? seed : hash_reg;
    assign rsm0 = s1_first_reg ? mmsh_pkg::RS_MUL_SEED : rsm_reg;
    assign odd0 = s1_first_reg ? 1'b0 : odd_reg;

    // One multiplier shared by RS, FNV and AP
    always_comb
    begin
        case (mode_reg)
            mmsh_pkg::MODE_RS:
            begin
                mul_a = h0;
                mul_b = rsm0;
            end
            mmsh_pkg::MODE_FNV:
            begin
                mul_a = h0;
                mul_b = mmsh_pkg::FNV_MUL;
            end
            default:
            begin
                mul_a = c;
                mul_b = h0 >> 3;
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign rsm_step = rsm0 * mmsh_pkg::RS_MUL_STEP;
    assign nib      = (h0 << 4) + c;

    always_comb
    begin
        rsm_next = rsm0;
        case (mode_reg)
            mmsh_pkg::MODE_RS:
            begin
                hash_next = mul_p + c;
                rsm_next  = rsm_step;
            end
            mmsh_pkg::MODE_JS:   hash_next = h0 ^ ((h0 << 5) + c + (h0 >> 2));
            mmsh_pkg::MODE_PJW,
            mmsh_pkg::MODE_ELF:
            begin
                if ((nib & mmsh_pkg::HIGH_NIBBLE) != '0)
                begin
                    hash_next = (nib ^ ((nib & mmsh_pkg::HIGH_NIBBLE) >> 24))
                                & ~mmsh_pkg::HIGH_NIBBLE;
                end
                else
                begin
                    hash_next = nib;
                end
            end
            mmsh_pkg::MODE_BKDR: hash_next = (h0 << 7) + (h0 << 1) + h0 + c;
            mmsh_pkg::MODE_SDBM: hash_next = c + (h0 << 6) + (h0 << 16) - h0;
            mmsh_pkg::MODE_DJB:  hash_next = (h0 << 5) + h0 + c;
            mmsh_pkg::MODE_DEK:  hash_next = ((h0 << 5) ^ (h0 >> 27)) ^ c;
            mmsh_pkg::MODE_BP:   hash_next = (h0 << 7) ^ c;
            mmsh_pkg::MODE_FNV:  hash_next = mul_p ^ c;
            mmsh_pkg::MODE_AP:
            begin
                if (!odd0)
                begin
                    hash_next = h0 ^ ((h0 << 7) ^ mul_p);
                end
                else
                begin
                    hash_next = h0 ^ ~(((h0 << 11) + c) ^ (h0 >> 5));
                end
            end
            default:             hash_next = h0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= '0;
            rsm_reg  <= mmsh_pkg::RS_MUL_SEED;
            odd_reg  <= 1'b0;
        end
        else if (s1_fire)
        begin
            hash_reg <= hash_next;
            rsm_reg  <= rsm_next;
            odd_reg  <= !odd0;
        end
    end

    // Output register
    assign out_valid_next = (out_valid_reg && !hash.ready) || (s1_fire && s1_last_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_last_reg)
        begin
            out_hash_reg <= hash_next;
        end
    end

    assign hash.valid      = out_valid_reg;
    assign hash.hash_value = out_hash_reg;

    `MMSH_ASSERT_SAME(a_mid_byte_never_waits, clk, rst_n,
        s1_valid_reg && !s1_last_reg, s1_fire)
    `MMSH_ASSERT_NEXT(a_last_byte_emits, clk, rst_n,
        s1_fire && s1_last_reg, out_valid_reg && (out_hash_reg == $past(hash_next)))
    `MMSH_ASSERT_NEXT(a_first_byte_sets_odd, clk, rst_n,
        s1_fire && s1_first_reg, odd_reg)
    `MMSH_ASSERT_NEXT(a_rs_mult_only_in_rs, clk, rst_n,
        s1_fire && !s1_first_reg && (mode_reg != mmsh_pkg::MODE_RS), $stable(rsm_reg))

endmodule
